>>> hdl/pwfe_pkg.sv
package pwfe_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned NUM_REGS    = 8;
  localparam int unsigned QDEPTH      = 4;
  localparam int unsigned QAW         = 2;
  localparam int unsigned QCW         = 3;
  localparam int unsigned STEP_W      = 4;
  localparam int unsigned M_TDATA_W   = 16;

  localparam logic [BYTE_W-1:0] LEAD_IN_UNITS = 8'd10;
  localparam logic [BYTE_W-1:0] TAIL_HIGH_UNITS = 8'd1;
  localparam logic [BYTE_W-1:0] HOLD_UNITS = 8'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_HIGH = 4'd0,
    REG_START_LOW  = 4'd1,
    REG_ONE_HIGH   = 4'd2,
    REG_ONE_LOW    = 4'd3,
    REG_ZERO_HIGH  = 4'd4,
    REG_ZERO_LOW   = 4'd5,
    REG_STOP_HIGH  = 4'd6,
    REG_STOP_LOW   = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic [BYTE_W-1:0] start_high_units;
    logic [BYTE_W-1:0] start_low_units;
    logic [BYTE_W-1:0] one_high_units;
    logic [BYTE_W-1:0] one_low_units;
    logic [BYTE_W-1:0] zero_high_units;
    logic [BYTE_W-1:0] zero_low_units;
    logic [BYTE_W-1:0] stop_high_units;
    logic [BYTE_W-1:0] stop_low_units;
  } cfg_t;

  // One classified item: what the back end must send for it
  typedef struct packed {
    logic              open_frame;
    logic              close_frame;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] checksum;
  } cmd_t;

  typedef struct packed {
    logic active;
  } back_stat_t;

endpackage

>>> hdl/pwfe_front.sv
module pwfe_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // data_byte
  input  logic               s_tlast,   // last_byte
  input  logic               q_full,
  output logic               q_push,
  output pwfe_pkg::cmd_t     q_cmd
);
  import pwfe_pkg::*;

  logic              in_frame;
  logic [BYTE_W-1:0] running_checksum;
  logic [BYTE_W-1:0] checksum_next;

  assign s_tready      = !q_full;
  assign q_push        = s_tvalid && s_tready;
  assign checksum_next = running_checksum ^ s_tdata;

  always_comb begin
    q_cmd.open_frame  = !in_frame;
    q_cmd.close_frame = s_tlast;
    q_cmd.data        = s_tdata;
    q_cmd.checksum    = checksum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame         <= 1'b0;
      running_checksum <= '0;
    end else if (q_push) begin
      in_frame         <= !s_tlast;
      // clear the checksum once the frame closes
      running_checksum <= s_tlast ? '0 : checksum_next;
    end
  end

endmodule

>>> hdl/pwfe_queue.sv
module pwfe_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  pwfe_pkg::cmd_t             push_cmd,
  input  logic                       pop,
  output pwfe_pkg::cmd_t             head,
  output logic                       full,
  output logic                       empty,
  output logic [pwfe_pkg::QCW-1:0]   count
);
  import pwfe_pkg::*;

  cmd_t           entries [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;

  assign full  = (count == QCW'(QDEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hdl/pwfe_back.sv
module pwfe_back (
  input  logic                  clk,
  input  logic                  rst,
  input  pwfe_pkg::cfg_t        cfg,
  input  logic                  q_empty,
  input  pwfe_pkg::cmd_t        q_head,
  output logic                  q_pop,
  output pwfe_pkg::back_stat_t  stat,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [15:0]           m_tdata,  // pin_level, duration_units, zero pad
  output logic                  m_tlast   // last_segment
);
  import pwfe_pkg::*;

  typedef enum logic [1:0] {
    PH_HEAD,
    PH_DATA,
    PH_CHECK,
    PH_TAIL
  } phase_t;

  phase_t            phase;
  logic              active;
  logic [STEP_W-1:0] step;
  cmd_t              cmd;

  logic              adv;
  logic              emit;
  logic              seg_last;
  logic              seg_level;
  logic [BYTE_W-1:0] seg_units;
  logic              phase_end;
  logic              bit_val;
  logic [BYTE_W-1:0] cur_byte;
  logic              out_level;
  logic [BYTE_W-1:0] out_units;

  assign adv   = !m_tvalid || m_tready;
  assign emit  = adv && active;
  assign q_pop = !q_empty && (!active || (emit && seg_last));
  assign stat.active = active;

  assign m_tdata = {{(M_TDATA_W - BYTE_W - 1){1'b0}}, out_units, out_level};

  always_comb begin
    cur_byte  = (phase == PH_CHECK) ? cmd.checksum : cmd.data;
    bit_val   = cur_byte[step[STEP_W-1:1]];
    seg_level = !step[0];
    phase_end = 1'b0;
    seg_units = HOLD_UNITS;
    case (phase)
      PH_HEAD: begin
        phase_end = (step == STEP_W'(3));
        case (step[1:0])
          2'd0:    seg_units = LEAD_IN_UNITS;
          2'd1:    seg_units = LEAD_IN_UNITS;
          2'd2:    seg_units = cfg.start_high_units;
          default: seg_units = cfg.start_low_units;
        endcase
      end
      PH_DATA, PH_CHECK: begin
        phase_end = (step == '1);
        if (bit_val) begin
          seg_units = step[0] ? cfg.one_low_units : cfg.one_high_units;
        end else begin
          seg_units = step[0] ? cfg.zero_low_units : cfg.zero_high_units;
        end
      end
      PH_TAIL: begin
        phase_end = (step == STEP_W'(3));
        case (step[1:0])
          2'd0:    seg_units = cfg.stop_high_units;
          2'd1:    seg_units = cfg.stop_low_units;
          2'd2:    seg_units = TAIL_HIGH_UNITS;
          default: seg_units = HOLD_UNITS;
        endcase
      end
      default: begin
        phase_end = 1'b1;
        seg_units = HOLD_UNITS;
      end
    endcase
    seg_last = phase_end &&
               ((phase == PH_TAIL) || ((phase == PH_DATA) && !cmd.close_frame));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      phase    <= PH_HEAD;
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (adv) begin
        m_tvalid  <= active;
        out_level <= seg_level;
        out_units <= seg_units;
        m_tlast   <= seg_last;
      end
      if (q_pop) begin
        // take the next item straight after the final segment
        active <= 1'b1;
        cmd    <= q_head;
        phase  <= q_head.open_frame ? PH_HEAD : PH_DATA;
        step   <= '0;
      end else if (emit) begin
        if (seg_last) begin
          active <= 1'b0;
        end else if (phase_end) begin
          step <= '0;
          case (phase)
            PH_HEAD:  phase <= PH_DATA;
            PH_DATA:  phase <= PH_CHECK;
            PH_CHECK: phase <= PH_TAIL;
            default:  phase <= PH_TAIL;
          endcase
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

endmodule

>>> hdl/pulse_width_frame_encoder.sv
// An item reaches m_tdata through the queue entry, the sequencer command register
// and the output register. Segments go out one per cycle while m_tready allows;
// a byte gives 16 segments, 20 if it opens a frame, 36 if it closes one, 40 if both.
// A four-entry command queue lets the input side run ahead of the segment sequencer.
// Reset (rst, synchronous) closes any open frame, clears the checksum and queue,
// and loads the default pulse lengths into the registers.
module pulse_width_frame_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // data_byte
  input  logic        s_tlast,    // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,    // pin_level, duration_units, zero pad
  output logic        m_tlast,    // last_segment
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import pwfe_pkg::*;

  cfg_t           cfg;
  logic           q_full;
  logic           q_empty;
  logic           q_push;
  logic           q_pop;
  logic [QCW-1:0] q_count;
  cmd_t           q_cmd;
  cmd_t           q_head;
  back_stat_t     stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_high_units <= 8'd30;
      cfg.start_low_units  <= 8'd70;
      cfg.one_high_units   <= 8'd5;
      cfg.one_low_units    <= 8'd10;
      cfg.zero_high_units  <= 8'd10;
      cfg.zero_low_units   <= 8'd5;
      cfg.stop_high_units  <= 8'd70;
      cfg.stop_low_units   <= 8'd30;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_START_HIGH: cfg.start_high_units <= cfg_data;
        REG_START_LOW:  cfg.start_low_units  <= cfg_data;
        REG_ONE_HIGH:   cfg.one_high_units   <= cfg_data;
        REG_ONE_LOW:    cfg.one_low_units    <= cfg_data;
        REG_ZERO_HIGH:  cfg.zero_high_units  <= cfg_data;
        REG_ZERO_LOW:   cfg.zero_low_units   <= cfg_data;
        REG_STOP_HIGH:  cfg.stop_high_units  <= cfg_data;
        REG_STOP_LOW:   cfg.stop_low_units   <= cfg_data;
        default:        cfg <= cfg; // drop writes beyond the register list
      endcase
    end
  end

  pwfe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  pwfe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty),
    .count    (q_count)
  );

  pwfe_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCW'(QDEPTH))
    else $error("command queue count beyond depth");

  a_idle_picks_up: assert property (@(posedge clk) disable iff (rst)
    !stat.active && !q_empty |=> stat.active)
    else $error("sequencer idle while commands wait");

  a_no_out_when_idle: assert property (@(posedge clk) disable iff (rst)
    !stat.active && (!m_tvalid || m_tready) |=> !m_tvalid)
    else $error("segment sent with no command in progress");

endmodule

>>> verif/tb_pulse_width_frame_encoder.sv
`timescale 1ns / 100ps

module tb_pulse_width_frame_encoder;
  import pwfe_pkg::*;

  typedef struct {
    bit       level;
    bit [7:0] units;
    bit       tail;
  } segment_t;

  class segment_scoreboard;
    localparam bit [7:0] LEAD_UNITS = 8'd10;

    segment_t    pending_segments[$];
    bit [7:0]    pulse_len[NUM_REGS];
    bit          frame_open;
    bit [7:0]    xor_sum;
    int unsigned errors;

    function new();
      pulse_len[REG_START_HIGH] = 8'd30;
      pulse_len[REG_START_LOW]  = 8'd70;
      pulse_len[REG_ONE_HIGH]   = 8'd5;
      pulse_len[REG_ONE_LOW]    = 8'd10;
      pulse_len[REG_ZERO_HIGH]  = 8'd10;
      pulse_len[REG_ZERO_LOW]   = 8'd5;
      pulse_len[REG_STOP_HIGH]  = 8'd70;
      pulse_len[REG_STOP_LOW]   = 8'd30;
      frame_open = 1'b0;
      xor_sum    = 8'd0;
      errors     = 0;
    endfunction

    // Indexes past the register list are dropped by the block
    function void write_reg(logic [3:0] idx, logic [7:0] val);
      if (idx < NUM_REGS) pulse_len[idx] = val;
    endfunction

    function void push_segment(bit level, bit [7:0] units);
      segment_t s;
      s.level = level;
      s.units = units;
      s.tail  = 1'b0;
      pending_segments.push_back(s);
    endfunction

    // LSB first, one high/low pair per bit
    function void push_bits(bit [7:0] b);
      for (int i = 0; i < 8; i++) begin
        if (b[i]) begin
          push_segment(1'b1, pulse_len[REG_ONE_HIGH]);
          push_segment(1'b0, pulse_len[REG_ONE_LOW]);
        end else begin
          push_segment(1'b1, pulse_len[REG_ZERO_HIGH]);
          push_segment(1'b0, pulse_len[REG_ZERO_LOW]);
        end
      end
    endfunction

    function void note_input(bit [7:0] b, bit last_b);
      segment_t s;
      if (!frame_open) begin
        push_segment(1'b1, LEAD_UNITS);
        push_segment(1'b0, LEAD_UNITS);
        push_segment(1'b1, pulse_len[REG_START_HIGH]);
        push_segment(1'b0, pulse_len[REG_START_LOW]);
        frame_open = 1'b1;
      end
      push_bits(b);
      xor_sum ^= b;
      if (last_b) begin
        push_bits(xor_sum);
        push_segment(1'b1, pulse_len[REG_STOP_HIGH]);
        push_segment(1'b0, pulse_len[REG_STOP_LOW]);
        push_segment(1'b1, 8'd1);
        push_segment(1'b0, 8'd0);
        frame_open = 1'b0;
        xor_sum    = 8'd0;
      end
      // mark the final segment of this item
      s = pending_segments.pop_back();
      s.tail = 1'b1;
      pending_segments.push_back(s);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 30) $display("ERROR at %0t: %s", $time, msg);
    endtask

    task check(logic [15:0] tdata, logic tlast);
      segment_t s;
      if (pending_segments.size() == 0) begin
        report($sformatf("unexpected segment tdata=%h tlast=%b", tdata, tlast));
      end else begin
        s = pending_segments.pop_front();
        if (tdata[0] !== s.level)
          report($sformatf("pin_level %b, expected %b", tdata[0], s.level));
        if (tdata[8:1] !== s.units)
          report($sformatf("duration_units %0d, expected %0d", tdata[8:1], s.units));
        if (tdata[15:9] !== 7'd0)
          report($sformatf("tdata pad bits %h not zero", tdata[15:9]));
        if (tlast !== s.tail)
          report($sformatf("last_segment %b, expected %b", tlast, s.tail));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [3:0]  cfg_index = 4'd0;
  logic [7:0]  cfg_data = 8'd0;

  segment_scoreboard sb = new();
  int                burst_left = 4;

  pulse_width_frame_encoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver back-pressure: switch between stall modes every stretch of cycles
  int unsigned stall_mode = 0;
  int unsigned mode_left  = 0;
  int unsigned cycle_cnt  = 0;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left  <= $urandom_range(20, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= (cycle_cnt % 3 == 0);
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check(m_tdata, m_tlast);
  end

  // Hold valid high across back-to-back items; drop it only for a gap
  task automatic drive_byte(input logic [7:0] b, input logic last_b);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last_b;
    do @(posedge clk); while (!s_tready);
    sb.note_input(b, last_b);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  endtask

  task automatic write_reg(input logic [3:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  // Program all eight registers, then poke one index past the list
  task automatic program_regs(input logic [7:0] vals[8]);
    for (int i = 0; i < 8; i++) write_reg(i[3:0], vals[i]);
    write_reg(4'($urandom_range(8, 15)), 8'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending_segments.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_payload();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Whole frames only, so every phase ends with the frame closed
  task automatic run_frames(input int n_items, input int max_len);
    int sent;
    int flen;
    sent = 0;
    while (sent < n_items) begin
      flen = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 24) : $urandom_range(1, max_len);
      for (int k = 0; k < flen; k++) drive_byte(rand_payload(), k == flen - 1);
      sent += flen;
    end
  endtask

  initial begin
    logic [7:0] vals[8];
    int         n;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: bit extremes, one-byte frames, zero checksum
    drive_byte(8'h00, 1'b1);
    drive_byte(8'hFF, 1'b1);
    drive_byte(8'h01, 1'b0);
    drive_byte(8'h80, 1'b0);
    drive_byte(8'hAA, 1'b0);
    drive_byte(8'h55, 1'b1);
    drive_byte(8'h3C, 1'b0);
    drive_byte(8'h3C, 1'b1);
    drain();

    foreach (vals[i]) vals[i] = 8'd255;
    program_regs(vals);
    run_frames(40, 6);
    drain();

    foreach (vals[i]) vals[i] = 8'd1;
    program_regs(vals);
    run_frames(40, 6);
    drain();

    // zero lengths go out unchanged
    foreach (vals[i]) vals[i] = 8'd0;
    program_regs(vals);
    run_frames(20, 4);
    drain();

    for (int p = 0; p < 4; p++) begin
      foreach (vals[i]) vals[i] = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      program_regs(vals);
      run_frames(42, 8);
      drain();
    end

    n = 0;
    while (sb.pending_segments.size() != 0 && n < 100000) begin
      @(posedge clk);
      n++;
    end
    repeat (20) @(posedge clk);
    if (sb.pending_segments.size() != 0)
      sb.report($sformatf("%0d segments never arrived", sb.pending_segments.size()));
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> filelist.f
hdl/pwfe_pkg.sv
hdl/pwfe_front.sv
hdl/pwfe_queue.sv
hdl/pwfe_back.sv
hdl/pulse_width_frame_encoder.sv
verif/tb_pulse_width_frame_encoder.sv
